// ===== src/salc_pkg.sv =====
`timescale 1ns / 1ps
package salc_pkg;
    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS = 8;
    localparam int STAMP_BITS = 32;
    localparam int WAY_W = $clog2(MAX_WAYS);
    localparam int SETS = 1 << MAX_SET_BITS;
    localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int QDEPTH = 2;

    localparam logic [1:0] OP_IFETCH = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_STORE  = 2'd2;
    localparam logic [1:0] OP_MODIFY = 2'd3;

    localparam logic [1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS       = 2'd2;

    // one lookup request handed from front to back
    typedef struct packed {
        logic [SET_W-1:0] set_idx;
        logic [63:0]      tag;
        logic             last;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic        evicted;
        logic [2:0]  way_used;
        logic        last;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] eviction_total;
    } res_t;
endpackage

// ===== src/salc_front.sv =====
`timescale 1ns / 1ps
module salc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_op,
    input  logic [63:0]         in_addr,
    input  logic [2:0]          set_bits,
    input  logic [5:0]          block_bits,
    output logic                q_valid,
    input  logic                q_ready,
    output salc_pkg::req_t      q_req
);
    import salc_pkg::*;

    logic        busy_reg;
    logic        second_reg;
    logic [63:0] addr_reg;
    logic [2:0]  s_eff;
    logic [6:0]  sb;
    logic [63:0] sh;

    // front holds one item; modify issues two lookups
    assign in_ready = !busy_reg || (q_ready && !second_reg);
    assign s_eff = (set_bits > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits;
    assign sb = 7'(s_eff) + 7'(block_bits);
    assign sh = addr_reg >> block_bits;
    assign q_valid = busy_reg;
    always_comb
    begin
        q_req.set_idx = SET_W'(sh & ((64'd1 << s_eff) - 64'd1));
        q_req.tag = (sb >= 7'd64) ? 64'd0 : (addr_reg >> sb[5:0]);
        q_req.last = !second_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            second_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            busy_reg <= (in_op != OP_IFETCH);
            second_reg <= (in_op == OP_MODIFY);
        end
        else if (busy_reg && q_ready)
        begin
            if (second_reg)
                second_reg <= 1'b0;
            else
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            addr_reg <= in_addr;
    end
endmodule

// ===== src/salc_queue.sv =====
`timescale 1ns / 1ps
module salc_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  salc_pkg::req_t wr_data,
    output logic           rd_valid,
    input  logic           rd_ready,
    output salc_pkg::req_t rd_data
);
    import salc_pkg::*;

    req_t      mem_reg [QDEPTH];
    logic      wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = cnt_reg != 2'(QDEPTH);
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_valid && wr_ready)
                wp_reg <= !wp_reg;
            if (rd_valid && rd_ready)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            mem_reg[wp_reg] <= wr_data;
    end
endmodule

// ===== src/salc_back.sv =====
`timescale 1ns / 1ps
module salc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  salc_pkg::req_t  q_req,
    input  logic [3:0]      ways,
    output logic            out_valid,
    input  logic            out_ready,
    output salc_pkg::res_t  out_res
);
    import salc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;
    localparam logic [1:0] ST_CLR  = 2'd3;

    logic [1:0] state_reg;
    logic [SET_W-1:0] clr_reg;
    // one set row per entry: all ways side by side
    logic [MAX_WAYS-1:0][63:0]           tag_mem [SETS];
    logic [MAX_WAYS-1:0][STAMP_BITS-1:0] stamp_mem [SETS];
    logic [MAX_WAYS-1:0]                 valid_mem [SETS];
    logic [MAX_WAYS-1:0][63:0]           tag_rd;
    logic [MAX_WAYS-1:0][STAMP_BITS-1:0] stamp_rd;
    logic [MAX_WAYS-1:0]                 vld_rd;
    req_t                                req_reg;
    logic [STAMP_BITS-1:0]               clock_reg;
    logic [31:0] hits_reg, miss_reg, evict_reg;
    res_t                                res_reg;

    logic [3:0]        e_eff;
    logic              found_hit, found_inv;
    logic [WAY_W-1:0]  hit_way, inv_way, lru_way, way_sel;
    logic [STAMP_BITS-1:0] best_age, age;
    logic [STAMP_BITS-1:0] clk_new;

    assign q_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_res = res_reg;
    assign clk_new = clock_reg + 1'b1;

    // way search over the registered row
    always_comb
    begin
        e_eff = (ways == 4'd0) ? 4'd1 : ((ways > 4'(MAX_WAYS)) ? 4'(MAX_WAYS) : ways);
        found_hit = 1'b0;
        found_inv = 1'b0;
        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        best_age = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            age = clk_new - stamp_rd[w];
            if (4'(w) < e_eff)
            begin
                if (!found_hit && vld_rd[w] && tag_rd[w] == req_reg.tag)
                begin
                    found_hit = 1'b1;
                    hit_way = WAY_W'(w);
                end
                if (!found_inv && !vld_rd[w])
                begin
                    found_inv = 1'b1;
                    inv_way = WAY_W'(w);
                end
                if (w == 0 || age > best_age)
                begin
                    best_age = age;
                    lru_way = WAY_W'(w);
                end
            end
        end
        way_sel = found_hit ? hit_way : (found_inv ? inv_way : lru_way);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLR;
            clr_reg <= '0;
            clock_reg <= '0;
            hits_reg <= '0;
            miss_reg <= '0;
            evict_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLR:
                begin
                    // one valid row cleared per cycle after reset
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SET_W'(SETS - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (q_valid)
                        state_reg <= ST_LOOK;
                end
                ST_LOOK:
                begin
                    clock_reg <= clk_new;
                    if (found_hit)
                        hits_reg <= (hits_reg == '1) ? hits_reg : hits_reg + 1'b1;
                    else
                    begin
                        miss_reg <= (miss_reg == '1) ? miss_reg : miss_reg + 1'b1;
                        if (!found_inv)
                            evict_reg <= (evict_reg == '1) ? evict_reg : evict_reg + 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_ready)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // row read, write-back and result capture
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLR)
            valid_mem[clr_reg] <= '0;
        if (state_reg == ST_IDLE && q_valid)
        begin
            req_reg <= q_req;
            tag_rd <= tag_mem[q_req.set_idx];
            stamp_rd <= stamp_mem[q_req.set_idx];
            vld_rd <= valid_mem[q_req.set_idx];
        end
        if (state_reg == ST_LOOK)
        begin
            valid_mem[req_reg.set_idx][way_sel] <= 1'b1;
            tag_mem[req_reg.set_idx][way_sel] <= req_reg.tag;
            stamp_mem[req_reg.set_idx][way_sel] <= clk_new;
            res_reg.hit <= found_hit;
            res_reg.evicted <= !found_hit && !found_inv;
            res_reg.way_used <= 3'(way_sel);
            res_reg.last <= req_reg.last;
            res_reg.hit_total <= found_hit ?
                ((hits_reg == '1) ? hits_reg : hits_reg + 1'b1) : hits_reg;
            res_reg.miss_total <= !found_hit ?
                ((miss_reg == '1) ? miss_reg : miss_reg + 1'b1) : miss_reg;
            res_reg.eviction_total <= (!found_hit && !found_inv) ?
                ((evict_reg == '1) ? evict_reg : evict_reg + 1'b1) : evict_reg;
        end
    end
endmodule

// ===== src/set_assoc_lru_cache_sim_unit.sv =====
`timescale 1ns / 1ps
// channel  | dir | payload
// s_axis   | in  | tdata: opcode[1:0], address[65:2]
// m_axis   | out | tdata: hit, evicted, way_used[4:2], totals; tlast: last
// cfg      | in  | index 0 set_bits, 1 block_bits, 2 ways
// A lookup passes three steps in the back part (row read, search and write-back,
// output); modify issues two lookups. The back part's three-step sequence sets the rate.
// Reset clears totals and the access clock at once; the valid bits are then
// cleared one set per cycle across all 64 sets, during which no lookup starts.
// A stalled m_axis holds the back part; the queue lets the front keep going.
module set_assoc_lru_cache_sim_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // opcode[1:0], address[65:2], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [103:0] m_axis_tdata,  // hit, evicted, way_used[4:2],
                                        // hit_total[36:5], miss_total[68:37],
                                        // eviction_total[100:69], zero
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import salc_pkg::*;

    logic [2:0] set_bits_reg;
    logic [5:0] block_bits_reg;
    logic [3:0] ways_reg;
    logic fq_valid, fq_ready, bq_valid, bq_ready;
    req_t fq_req, bq_req;
    res_t res;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg <= 3'd0;
            block_bits_reg <= 6'd4;
            ways_reg <= 4'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SET_BITS:   set_bits_reg <= cfg_data[2:0];
                CFG_BLOCK_BITS: block_bits_reg <= cfg_data[5:0];
                CFG_WAYS:       ways_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    salc_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_op(s_axis_tdata[1:0]), .in_addr(s_axis_tdata[65:2]),
        .set_bits(set_bits_reg), .block_bits(block_bits_reg),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_req(fq_req)
    );

    salc_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_req),
        .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_req)
    );

    salc_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(bq_valid), .q_ready(bq_ready), .q_req(bq_req),
        .ways(ways_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
    );

    assign m_axis_tdata = {3'd0, res.eviction_total, res.miss_total, res.hit_total,
                           res.way_used, res.evicted, res.hit};
    assign m_axis_tlast = res.last;
endmodule

// ===== src/salc_checker.sv =====
`timescale 1ns / 1ps
module salc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [103:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable({m_axis_tlast, m_axis_tdata}))
        else $error("result changed under stall");
    // hit and evicted never both set
    a_he: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("hit with eviction");
    // a hit result carries a nonzero hit total
    a_ht: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[36:5] != 32'd0)
        else $error("hit total zero on hit");
    // eviction implies a miss was counted
    a_ev: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[68:37] != 32'd0)
        else $error("miss total zero on eviction");
endmodule

bind set_assoc_lru_cache_sim_unit salc_checker u_checker (
    .clk(clk), .rst_n(rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast)
);

// ===== bench/set_assoc_lru_cache_sim_unit_test.sv =====
`timescale 1ns / 1ps
module set_assoc_lru_cache_sim_unit_test;
    import salc_pkg::*;

    localparam int LINES = SETS * MAX_WAYS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    // one row of the directed table; typed expectation only where obvious
    typedef struct {
        logic [1:0]  op;
        logic [63:0] addr;
        bit          typed;
        logic        hit;
        logic        evicted;
        logic [2:0]  way;
    } vec_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         m_axis_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = CFG_SET_BITS;
    logic [31:0]  cfg_data = '0;

    // predictor state
    bit          line_ok [LINES];
    logic [63:0] line_tag [LINES];
    logic [31:0] line_age [LINES];
    logic [31:0] lru_clock;
    logic [31:0] hit_cnt, miss_cnt, evict_cnt;
    logic [2:0]  cur_set_bits;
    logic [5:0]  cur_block_bits;
    logic [3:0]  cur_ways;

    res_t pending_results [$];

    int  errors = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  evictions_seen_tb = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 0;
    bit  sending = 0;

    set_assoc_lru_cache_sim_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic predictor_clear();
        for (int i = 0; i < LINES; i++)
        begin
            line_ok[i] = 0;
            line_tag[i] = '0;
            line_age[i] = '0;
        end
        lru_clock = '0;
        hit_cnt = '0;
        miss_cnt = '0;
        evict_cnt = '0;
        cur_set_bits = 3'd0;
        cur_block_bits = 6'd4;
        cur_ways = 4'd1;
    endtask

    // one tag lookup with LRU update
    task automatic cache_lookup(input logic [63:0] addr, input logic lst, output res_t r);
        int s, b, e, base, way;
        logic [63:0] set_idx, tg;
        logic [31:0] age, best;
        bit found;
        s = (int'(cur_set_bits) > MAX_SET_BITS) ? MAX_SET_BITS : int'(cur_set_bits);
        b = int'(cur_block_bits);
        e = (cur_ways == 4'd0) ? 1 :
            ((int'(cur_ways) > MAX_WAYS) ? MAX_WAYS : int'(cur_ways));
        found = 0;
        way = 0;
        best = '0;
        lru_clock = lru_clock + 32'd1;
        set_idx = (addr >> b) & ((64'd1 << s) - 64'd1);
        tg = (s + b >= 64) ? 64'd0 : (addr >> (s + b));
        base = int'(set_idx) * MAX_WAYS;
        r = '0;
        r.last = lst;
        for (int w = 0; w < e && !found; w++)
            if (line_ok[base + w] && line_tag[base + w] == tg)
            begin
                found = 1;
                way = w;
            end
        if (found)
        begin
            r.hit = 1'b1;
            hit_cnt = sat_inc(hit_cnt);
            line_age[base + way] = lru_clock;
        end
        else
        begin
            miss_cnt = sat_inc(miss_cnt);
            for (int w = 0; w < e && !found; w++)
                if (!line_ok[base + w])
                begin
                    found = 1;
                    way = w;
                end
            if (!found)
            begin
                r.evicted = 1'b1;
                evict_cnt = sat_inc(evict_cnt);
                for (int w = 0; w < e; w++)
                begin
                    age = lru_clock - line_age[base + w];
                    if (w == 0 || age > best)
                    begin
                        best = age;
                        way = w;
                    end
                end
            end
            line_ok[base + way] = 1;
            line_tag[base + way] = tg;
            line_age[base + way] = lru_clock;
        end
        r.way_used = way[2:0];
        r.hit_total = hit_cnt;
        r.miss_total = miss_cnt;
        r.eviction_total = evict_cnt;
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        errors++;
        $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
    endtask

    // drive one item, wait for acceptance, queue what it should produce
    task automatic send_item(input logic [1:0] op, input logic [63:0] addr,
                             input bit typed, input vec_t row);
        res_t r;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, addr, op};
        sending = 1;
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
        items_sent++;
        if (op == OP_LOAD || op == OP_STORE)
        begin
            cache_lookup(addr, 1'b1, r);
            if (typed)
            begin
                r.hit = row.hit;
                r.evicted = row.evicted;
                r.way_used = row.way;
            end
            pending_results.push_back(r);
        end
        else if (op == OP_MODIFY)
        begin
            cache_lookup(addr, 1'b0, r);
            pending_results.push_back(r);
            cache_lookup(addr, 1'b1, r);
            pending_results.push_back(r);
        end
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            sending = 0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // let everything drain, then wait out a trailing fetch
    task automatic drain();
        if (sending)
        begin
            s_axis_tvalid <= 1'b0;
            sending = 0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SET_BITS:   cur_set_bits = val[2:0];
            CFG_BLOCK_BITS: cur_block_bits = val[5:0];
            CFG_WAYS:       cur_ways = val[3:0];
            default: ;
        endcase
    endtask

    // mostly a small pool of tags over a few sets so hits and LRU evictions happen
    function automatic logic [63:0] pick_addr();
        int s, b;
        logic [63:0] tg, st, off;
        s = (int'(cur_set_bits) > MAX_SET_BITS) ? MAX_SET_BITS : int'(cur_set_bits);
        b = int'(cur_block_bits);
        off = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 15)
            return off;
        tg = 64'($urandom_range(0, cur_ways + 2));
        if ($urandom_range(0, 9) == 0)
            tg = tg | {$urandom, $urandom};
        st = 64'($urandom_range(0, 3));
        return ((s + b >= 64) ? 64'd0 : (tg << (s + b)))
             | ((st & ((64'd1 << s) - 64'd1)) << b)
             | (off & ((b >= 64) ? '1 : ((64'd1 << b) - 64'd1)));
    endfunction

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            else
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        res_t want, got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '0;
            got.hit = m_axis_tdata[0];
            got.evicted = m_axis_tdata[1];
            got.way_used = m_axis_tdata[4:2];
            got.last = m_axis_tlast;
            got.hit_total = m_axis_tdata[36:5];
            got.miss_total = m_axis_tdata[68:37];
            got.eviction_total = m_axis_tdata[100:69];
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("unexpected result %0d", results_seen);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.evicted)
                    evictions_seen_tb++;
                if (got.hit != want.hit)
                    report("hit", 64'(got.hit), 64'(want.hit));
                if (got.evicted != want.evicted)
                    report("evicted", 64'(got.evicted), 64'(want.evicted));
                if (got.way_used != want.way_used)
                    report("way", 64'(got.way_used), 64'(want.way_used));
                if (got.last != want.last)
                    report("last", 64'(got.last), 64'(want.last));
                if (got.hit_total != want.hit_total)
                    report("hit_total", 64'(got.hit_total), 64'(want.hit_total));
                if (got.miss_total != want.miss_total)
                    report("miss_total", 64'(got.miss_total), 64'(want.miss_total));
                if (got.eviction_total != want.eviction_total)
                    report("eviction_total", 64'(got.eviction_total),
                           64'(want.eviction_total));
            end
        end
    end

    // stimulus
    initial
    begin
        vec_t dir_rows [$];
        vec_t row;
        int cfg_list [8][3];
        int phase;
        int idle_mode;
        logic [1:0] op;

        // directed table, reset setup: one set, one way, 16-byte lines
        dir_rows = '{
            '{OP_LOAD,   64'h0,                   1, 0, 0, 0},
            '{OP_LOAD,   64'h0,                   1, 1, 0, 0},
            '{OP_LOAD,   64'hF,                   1, 1, 0, 0},
            '{OP_STORE,  64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 1, 0},
            '{OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFF0, 0, 0, 0, 0},
            '{OP_IFETCH, 64'h1234_0000_0000_0000, 0, 0, 0, 0},
            '{OP_IFETCH, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0},
            '{OP_MODIFY, 64'h5555_5555_5555_5555, 0, 0, 0, 0},
            '{OP_LOAD,   64'hAAAA_AAAA_AAAA_AAAA, 1, 0, 1, 0},
            '{OP_STORE,  64'hAAAA_AAAA_AAAA_AAA0, 1, 1, 0, 0},
            '{OP_LOAD,   64'h8000_0000_0000_0000, 0, 0, 0, 0},
            '{OP_STORE,  64'h0000_0000_0000_0010, 0, 0, 0, 0},
            '{OP_MODIFY, 64'h0000_0000_0000_0010, 0, 0, 0, 0}
        };
        // set_bits, block_bits, ways: extremes and out-of-range values included
        cfg_list = '{'{7, 0, 15}, '{6, 63, 8}, '{0, 32, 0}, '{2, 5, 3},
                     '{6, 58, 8}, '{3, 60, 4}, '{1, 10, 2}, '{4, 6, 7}};

        predictor_clear();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            send_item(row.op, row.addr, row.typed, row);
        end
        drain();

        // random phases, each under its own setup and idling mix
        for (phase = 0; phase < 8; phase++)
        begin
            cfg_write(CFG_SET_BITS, cfg_list[phase][0]);
            cfg_write(CFG_BLOCK_BITS, cfg_list[phase][1]);
            cfg_write(CFG_WAYS, cfg_list[phase][2]);
            idle_mode = phase % 4;
            send_idle_pct = (idle_mode == 1) ? 72 : ((idle_mode == 3) ? 29 : 0);
            recv_stall_pct = (idle_mode == 2) ? 72 : ((idle_mode == 3) ? 29 : 0);
            if (phase == 0)
                hold_req = 1;
            for (int n = 0; n < 110; n++)
            begin
                op = 2'($urandom_range(0, 3));
                if (op == OP_IFETCH && $urandom_range(0, 1))
                    op = OP_LOAD;
                send_item(op, pick_addr(), 0, row);
            end
            drain();
        end

        $display("%0d items sent under 9 cache setups, %0d results checked, %0d evictions",
                 items_sent, results_seen, evictions_seen_tb);
        $display("covered idling mixes, a long output hold-off and %0d mismatches", errors);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
